[design/gda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date arithmetic package
// Field widths, day-count constants, month table and sequencer states.
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int YEAR_MAX  = 9999;
    localparam int YEAR_BIAS = 400;

    localparam int ACT_W   = 2;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 23;

    // Internal year is biased and shifted so that the year starts in March
    localparam int YEAR_IN_MAX = (1 << YEAR_W) - 1;
    localparam int YY_MAX = ((YEAR_MAX > YEAR_IN_MAX) ? YEAR_MAX : YEAR_IN_MAX) + YEAR_BIAS;
    localparam int YY_W   = $clog2(YY_MAX + 1);
    localparam int SER_W  = $clog2((YY_MAX + 1) * 366 + 1);
    localparam int CNT_W  = $clog2(YY_W);
    localparam int DOY_W  = 9;
    localparam int MP_W   = 4;
    localparam int MONTHS = 12;
    localparam int DAYS_YEAR = 365;

    // floor(x / 100) as (x * RECIP_K) >> RECIP_SH, exact over the year range
    localparam int RECIP_SH = 24;
    localparam int RECIP_K  = (1 << RECIP_SH) / 100 + 1;
    localparam int RK_W     = $clog2(RECIP_K + 1);

    // March-based month index of January and December
    localparam int MP_JAN = 10;
    localparam int MP_DEC = 9;

    localparam int DB_MAX = (1 << (OFF_W - 1)) - 1;
    localparam int DB_MIN = -(1 << (OFF_W - 1));

    typedef logic [ACT_W-1:0]   t_action;
    typedef logic [YEAR_W-1:0]  t_year;
    typedef logic [MONTH_W-1:0] t_month;
    typedef logic [DAY_W-1:0]   t_day;
    typedef logic [MP_W-1:0]    t_mp;
    typedef logic [DOY_W-1:0]   t_doy;
    typedef logic [YY_W-1:0]    t_yy;

    localparam t_action ACT_ADD  = 2'd0;
    localparam t_action ACT_DIFF = 2'd1;
    localparam t_action ACT_CMP  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_MUL,
        S_A_ADD,
        S_B_MUL,
        S_B_ADD,
        S_CLAMP,
        S_SRCH_MUL,
        S_SRCH_ADD,
        S_FIN
    } t_state;

    // First day of each month counted from March 1
    function automatic t_doy f_mstart(input t_mp mp);
        t_doy v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic t_month f_mclamp(input t_month m);
        t_month v;
        if (m < 4'd1) begin
            v = 4'd1;
        end else if (m > 4'd12) begin
            v = 4'd12;
        end else begin
            v = m;
        end
        return v;
    endfunction

    function automatic t_mp f_mp(input t_month m);
        t_month mc;
        mc = f_mclamp(m);
        return (mc > 4'd2) ? t_mp'(mc - 4'd3) : t_mp'(mc + 4'd9);
    endfunction

    // January and February belong to the previous March-based year
    function automatic t_yy f_yy(input t_year y, input t_month m);
        t_month mc;
        mc = f_mclamp(m);
        return t_yy'(y) + t_yy'(YEAR_BIAS) - ((mc <= 4'd2) ? t_yy'(1) : t_yy'(0));
    endfunction

    localparam int LO_YY  = YEAR_BIAS;
    localparam int SER_LO = DAYS_YEAR * LO_YY + LO_YY / 4 - LO_YY / 100 + LO_YY / 400
                          + int'(f_mstart(t_mp'(MP_JAN)));
    localparam int HI_YY  = YEAR_MAX + YEAR_BIAS;
    localparam int SER_HI = DAYS_YEAR * HI_YY + HI_YY / 4 - HI_YY / 100 + HI_YY / 400
                          + int'(f_mstart(t_mp'(MP_DEC))) + 30;

endpackage

[design/gda_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date arithmetic channels
// Request and response channels with valid / ready handshake.
// ----------------------------------------------------------------------------
interface gda_req_if;
    import gda_pkg::*;

    logic                      valid;
    logic                      ready;
    t_action                   action;
    t_year                     year_a;
    t_month                    month_a;
    t_day                      day_a;
    t_year                     year_b;
    t_month                    month_b;
    t_day                      day_b;
    logic signed [OFF_W-1:0]   offset;

    modport source (
        output valid, action, year_a, month_a, day_a, year_b, month_b, day_b, offset,
        input  ready
    );
    modport sink (
        input  valid, action, year_a, month_a, day_a, year_b, month_b, day_b, offset,
        output ready
    );
endinterface

interface gda_rsp_if;
    import gda_pkg::*;

    logic                      valid;
    logic                      ready;
    t_year                     year_out;
    t_month                    month_out;
    t_day                      day_out;
    logic signed [OFF_W-1:0]   days_between;
    logic                      a_equal_b;
    logic                      a_greater_b;
    logic                      a_less_b;
    logic                      range_error;

    modport source (
        output valid, year_out, month_out, day_out, days_between,
               a_equal_b, a_greater_b, a_less_b, range_error,
        input  ready
    );
    modport sink (
        input  valid, year_out, month_out, day_out, days_between,
               a_equal_b, a_greater_b, a_less_b, range_error,
        output ready
    );
endinterface

[design/gda_days_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date arithmetic day-count unit
// Days before March 1 of a biased year: 365y + y/4 - y/100 + y/400.
// Products are registered; the sum follows in the cycle after the year.
// ----------------------------------------------------------------------------
module gda_days_unit (
    input  logic                     i_clk,
    input  logic [gda_pkg::YY_W-1:0] i_yy,
    output logic [gda_pkg::SER_W:0]  o_days
);
    import gda_pkg::*;

    logic [YY_W+RK_W-1:0] n_prod;
    logic [SER_W:0]       r_y365;
    logic [YY_W-1:0]      r_q100;
    logic [YY_W-1:0]      r_q4;

    assign n_prod = (YY_W + RK_W)'(i_yy) * (YY_W + RK_W)'(RECIP_K);

    always_ff @(posedge i_clk) begin
        r_y365 <= (SER_W + 1)'(i_yy) * (SER_W + 1)'(DAYS_YEAR);
        r_q100 <= YY_W'(n_prod >> RECIP_SH);
        r_q4   <= i_yy >> 2;
    end

    assign o_days = r_y365 + (SER_W + 1)'(r_q4) - (SER_W + 1)'(r_q100)
                  + (SER_W + 1)'(r_q100 >> 2);

endmodule

[design/gregorian_date_arithmetic_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date arithmetic unit
// Adds a day offset to a date, takes the day difference of two dates and
// compares them, with saturation and a range error flag.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request item: action, date A, date B and a signed
//   offset. o_rsp returns one result item per request.
//   Both dates are turned into day serials through one shared day-count
//   unit, the result serial is clamped, then the year is recovered by a
//   bit-by-bit search that runs the same unit once per year bit, for all
//   YY_W bits of the internal year (YY_W = 15 with the default year range).
//   One request is in work at a time: i_req.ready is high only in idle, so
//   a new request is taken only once the previous item has left the sequencer.
//   The result sits in an output register; a new request is taken while it
//   waits, and the finished item holds in the sequencer until the receiver
//   frees the output register.
//   Reset returns the sequencer to idle and drops any pending result.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gda_req_if.sink    i_req,
    gda_rsp_if.source  o_rsp
);
    import gda_pkg::*;

    t_state                r_state, n_state;
    t_action               r_act, n_act;
    t_year                 r_ya, n_ya, r_yb, n_yb;
    t_month                r_ma, n_ma, r_mb, n_mb;
    t_day                  r_daya, n_daya, r_dayb, n_dayb;
    logic signed [OFF_W-1:0] r_off, n_off;
    logic [SER_W-1:0]      r_sa, n_sa, r_sb, n_sb;
    logic [SER_W-1:0]      r_z, n_z, r_dbk, n_dbk;
    t_yy                   r_yy, n_yy;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_rerr, n_rerr;
    logic signed [OFF_W-1:0] r_diff, n_diff;
    logic                  r_eq, n_eq, r_gt, n_gt, r_lt, n_lt;

    logic                  r_ovalid, n_ovalid;
    logic                  w_load;
    t_year                 r_o_year;
    t_month                r_o_month;
    t_day                  r_o_day;
    logic signed [OFF_W-1:0] r_o_diff;
    logic                  r_o_eq, r_o_gt, r_o_lt, r_o_rerr;

    t_yy                   w_unit_yy;
    t_yy                   w_trial;
    logic [SER_W:0]        w_days;
    logic [SER_W-1:0]      w_ser;
    logic signed [SER_W+1:0] w_res;
    logic signed [SER_W:0] w_dif;
    t_doy                  w_doy;
    t_mp                   w_mp;
    t_month                w_mon;
    t_day                  w_dom;
    t_year                 w_year;

    gda_days_unit u_days (
        .i_clk  (i_clk),
        .i_yy   (w_unit_yy),
        .o_days (w_days)
    );

    assign w_trial = r_yy | (t_yy'(1) << r_cnt);

    always_comb begin
        case (r_state)
            S_A_MUL: w_unit_yy = f_yy(r_ya, r_ma);
            S_B_MUL: w_unit_yy = f_yy(r_yb, r_mb);
            default: w_unit_yy = w_trial;
        endcase
    end

    // Serial of a date: days before its March-based year plus day of year
    always_comb begin
        if (r_state == S_A_ADD) begin
            w_ser = SER_W'(w_days + (SER_W + 1)'(f_mstart(f_mp(r_ma)))
                  + (SER_W + 1)'(r_daya) - (SER_W + 1)'(1));
        end else begin
            w_ser = SER_W'(w_days + (SER_W + 1)'(f_mstart(f_mp(r_mb)))
                  + (SER_W + 1)'(r_dayb) - (SER_W + 1)'(1));
        end
    end

    assign w_res = $signed({2'b00, r_sa})
                 + ((r_act == ACT_ADD) ? (SER_W + 2)'(r_off) : '0);
    assign w_dif = $signed({1'b0, r_sa}) - $signed({1'b0, r_sb});

    // Split the day of year into month and day
    assign w_doy = DOY_W'(r_z - r_dbk);

    always_comb begin
        w_mp = '0;
        for (int k = 0; k < MONTHS; k++) begin
            if (f_mstart(MP_W'(k)) <= w_doy) begin
                w_mp = MP_W'(k);
            end
        end
    end

    assign w_dom  = DAY_W'(w_doy - f_mstart(w_mp) + t_doy'(1));
    assign w_mon  = (w_mp < t_mp'(MP_JAN)) ? t_month'(w_mp + 4'd3) : t_month'(w_mp - 4'd9);
    assign w_year = YEAR_W'(r_yy + ((w_mon <= 4'd2) ? t_yy'(1) : t_yy'(0))
                  - t_yy'(YEAR_BIAS));

    assign w_load = (r_state == S_FIN) && (!r_ovalid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        n_ya    = r_ya;
        n_ma    = r_ma;
        n_daya  = r_daya;
        n_yb    = r_yb;
        n_mb    = r_mb;
        n_dayb  = r_dayb;
        n_off   = r_off;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_z     = r_z;
        n_dbk   = r_dbk;
        n_yy    = r_yy;
        n_cnt   = r_cnt;
        n_rerr  = r_rerr;
        n_diff  = r_diff;
        n_eq    = r_eq;
        n_gt    = r_gt;
        n_lt    = r_lt;
        n_ovalid = (r_ovalid && !o_rsp.ready) || w_load;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_act   = i_req.action;
                    n_ya    = i_req.year_a;
                    n_ma    = i_req.month_a;
                    n_daya  = i_req.day_a;
                    n_yb    = i_req.year_b;
                    n_mb    = i_req.month_b;
                    n_dayb  = i_req.day_b;
                    n_off   = i_req.offset;
                    n_state = S_A_MUL;
                end
            end
            S_A_MUL: n_state = S_A_ADD;
            S_A_ADD: begin
                n_sa    = w_ser;
                n_state = S_B_MUL;
            end
            S_B_MUL: n_state = S_B_ADD;
            S_B_ADD: begin
                n_sb    = w_ser;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                n_rerr = 1'b0;
                if (w_res < SER_LO) begin
                    n_z    = SER_W'(SER_LO);
                    n_rerr = 1'b1;
                end else if (w_res > SER_HI) begin
                    n_z    = SER_W'(SER_HI);
                    n_rerr = 1'b1;
                end else begin
                    n_z = SER_W'(w_res);
                end
                n_diff = '0;
                if (r_act == ACT_DIFF) begin
                    if (w_dif > DB_MAX) begin
                        n_diff = OFF_W'(DB_MAX);
                    end else if (w_dif < DB_MIN) begin
                        n_diff = OFF_W'(DB_MIN);
                    end else begin
                        n_diff = OFF_W'(w_dif);
                    end
                end
                n_eq    = (r_sa == r_sb);
                n_gt    = (r_sa > r_sb);
                n_lt    = (r_sa < r_sb);
                n_yy    = '0;
                n_dbk   = '0;
                n_cnt   = CNT_W'(YY_W - 1);
                n_state = S_SRCH_MUL;
            end
            S_SRCH_MUL: n_state = S_SRCH_ADD;
            S_SRCH_ADD: begin
                // keep the bit when its year still starts on or before the target
                if (w_days <= (SER_W + 1)'(r_z)) begin
                    n_yy  = w_trial;
                    n_dbk = SER_W'(w_days);
                end
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_SRCH_MUL;
                end
            end
            S_FIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_ya   <= n_ya;
        r_ma   <= n_ma;
        r_daya <= n_daya;
        r_yb   <= n_yb;
        r_mb   <= n_mb;
        r_dayb <= n_dayb;
        r_off  <= n_off;
        r_sa   <= n_sa;
        r_sb   <= n_sb;
        r_z    <= n_z;
        r_dbk  <= n_dbk;
        r_yy   <= n_yy;
        r_cnt  <= n_cnt;
        r_rerr <= n_rerr;
        r_diff <= n_diff;
        r_eq   <= n_eq;
        r_gt   <= n_gt;
        r_lt   <= n_lt;
        if (w_load) begin
            r_o_year  <= w_year;
            r_o_month <= w_mon;
            r_o_day   <= w_dom;
            r_o_diff  <= r_diff;
            r_o_eq    <= r_eq;
            r_o_gt    <= r_gt;
            r_o_lt    <= r_lt;
            r_o_rerr  <= r_rerr;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.year_out     = r_o_year;
    assign o_rsp.month_out    = r_o_month;
    assign o_rsp.day_out      = r_o_day;
    assign o_rsp.days_between = r_o_diff;
    assign o_rsp.a_equal_b    = r_o_eq;
    assign o_rsp.a_greater_b  = r_o_gt;
    assign o_rsp.a_less_b     = r_o_lt;
    assign o_rsp.range_error  = r_o_rerr;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while an item is in work");

    a_one_relation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> $onehot({o_rsp.a_equal_b, o_rsp.a_greater_b, o_rsp.a_less_b}))
        else $error("comparison flags not exactly one");

    a_date_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.month_out >= 4'd1) && (o_rsp.month_out <= 4'd12)
                     && (o_rsp.day_out != '0))
        else $error("result date outside calendar");

    a_load_on_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_ovalid && !o_rsp.ready) |=> (r_state == S_FIN))
        else $error("finished item dropped while output held");

endmodule
